FILE: hw/rtl/ahfd_pkg.sv
package ahfd_pkg;

    // Frame and counter sizing
    localparam int MAX_FRAME_BYTES = 4096;
    localparam int RUNT_LIMIT      = 5;
    localparam int CNT_W           = 13;
    localparam int RAW_W           = 3;
    localparam int QUEUE_DEPTH     = 4;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [RAW_W-1:0] t_raw;

    // Octet codes of the async HDLC framing
    localparam logic [7:0] FLAG_BYTE    = 8'h7e;
    localparam logic [7:0] ESC_BYTE     = 8'h7d;
    localparam logic [7:0] ESC_XOR      = 8'h20;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] ADDR_BYTE    = 8'hff;
    localparam logic [7:0] CTRL_ESC_ARG = 8'h23;

    // FCS-16, reflected polynomial
    localparam logic [15:0] FCS_INIT   = 16'hffff;
    localparam logic [15:0] FCS_GOOD   = 16'hf0b8;
    localparam logic [15:0] FCS_PREFIX = 16'h3de3;
    localparam logic [15:0] FCS_POLY   = 16'h8408;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_FCS  = 2'd1,
        STAT_OVERFLOW = 2'd2,
        STAT_RUNT     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_DATA   = 2'd0,
        CMD_PREFIX = 2'd1,
        CMD_CLOSE  = 2'd2
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_START,
        ST_GOT_FF,
        ST_GOT_7D,
        ST_BODY
    } t_front_state;

    // Work handed from the front to the back
    typedef struct packed {
        t_cmd_kind  kind;
        logic       hold_ff;
        logic       byte_vld;
        logic       runt;
        logic [7:0] data;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        t_status    status;
        t_cnt       length;
        logic       last;
    } t_result;

    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] x;
        x = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ FCS_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

FILE: hw/rtl/ahfd_front.sv
module ahfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_full,
    output logic          o_push,
    output ahfd_pkg::t_cmd o_cmd
);
    import ahfd_pkg::*;

    t_front_state r_state, n_state;
    logic         r_esc, n_esc;
    t_raw         r_raw, n_raw;

    logic       accept;
    logic       do_proc;
    logic       esc_in;
    t_cmd       cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Hold framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_esc   <= 1'b0;
            r_raw   <= '0;
        end else begin
            r_state <= n_state;
            r_esc   <= n_esc;
            r_raw   <= n_raw;
        end
    end

    // Classify the octet: flag, prefix, escape, control or data
    always_comb begin
        n_state      = r_state;
        n_esc        = r_esc;
        n_raw        = r_raw;
        do_proc      = 1'b0;
        esc_in       = r_esc;
        cmd          = '0;
        cmd.kind     = CMD_DATA;
        o_push       = 1'b0;
        if (accept) begin
            if (r_state == ST_HUNT) begin
                if (i_data == FLAG_BYTE) begin
                    n_state = ST_START;
                    n_esc   = 1'b0;
                    n_raw   = '0;
                end
            end else if (i_data == FLAG_BYTE) begin
                // closing flag also opens the next frame
                cmd.kind    = CMD_CLOSE;
                cmd.hold_ff = (r_state == ST_GOT_FF) || (r_state == ST_GOT_7D);
                cmd.runt    = (r_raw < t_raw'(RUNT_LIMIT));
                o_push      = 1'b1;
                n_state     = ST_START;
                n_esc       = 1'b0;
                n_raw       = '0;
            end else begin
                if (r_raw < t_raw'(RUNT_LIMIT)) begin
                    n_raw = r_raw + 1'b1;
                end
                unique case (r_state)
                    ST_START: begin
                        if (i_data == ADDR_BYTE) begin
                            n_state = ST_GOT_FF;
                        end else begin
                            n_state = ST_BODY;
                            do_proc = 1'b1;
                        end
                    end
                    ST_GOT_FF: begin
                        if (i_data == ESC_BYTE) begin
                            n_state = ST_GOT_7D;
                        end else begin
                            n_state     = ST_BODY;
                            cmd.hold_ff = 1'b1;
                            esc_in      = 1'b0;
                            do_proc     = 1'b1;
                        end
                    end
                    ST_GOT_7D: begin
                        n_state = ST_BODY;
                        if (i_data == CTRL_ESC_ARG) begin
                            cmd.kind = CMD_PREFIX;
                            o_push   = 1'b1;
                        end else begin
                            // held ff and 7d are decoded ahead of this octet
                            cmd.hold_ff = 1'b1;
                            esc_in      = 1'b1;
                            n_esc       = 1'b1;
                            do_proc     = 1'b1;
                        end
                    end
                    default: begin
                        do_proc = 1'b1;
                    end
                endcase
                if (do_proc) begin
                    if (i_data < CTRL_LIMIT) begin
                        n_esc = esc_in;
                    end else if (i_data == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc        = 1'b0;
                        cmd.byte_vld = 1'b1;
                        cmd.data     = esc_in ? (i_data ^ ESC_XOR) : i_data;
                    end
                    o_push = cmd.hold_ff || cmd.byte_vld;
                end
            end
        end
        o_cmd = cmd;
    end

endmodule

FILE: hw/rtl/ahfd_queue.sv
module ahfd_queue #(
    parameter int DEPTH = ahfd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ahfd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_vld,
    output ahfd_pkg::t_cmd o_cmd
);
    import ahfd_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_cmd              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/ahfd_back.sv
module ahfd_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [ahfd_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                    i_cmd_vld,
    input  ahfd_pkg::t_cmd          i_cmd,
    output logic                    o_pop,
    output logic                    o_out_vld,
    input  logic                    i_out_ready,
    output ahfd_pkg::t_result       o_res
);
    import ahfd_pkg::*;

    t_cnt        r_max_decoded;
    t_cnt        r_cnt, n_cnt;
    logic [15:0] r_fcs, n_fcs;
    logic        r_ovf, n_ovf;
    logic        r_phase, n_phase;
    logic        r_out_vld, n_out_vld;
    t_result     r_out, n_out;

    t_cnt        limit;
    logic        room_now, room_next, adv, more;

    assign o_cfg_ready = 1'b1;
    assign o_out_vld   = r_out_vld;
    assign o_res       = r_out;

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_decoded <= t_cnt'(MAX_FRAME_BYTES);
        end else if (i_cfg_valid) begin
            r_max_decoded <= i_cfg_data;
        end
    end

    // Hold frame accumulators and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_fcs     <= FCS_INIT;
            r_ovf     <= 1'b0;
            r_phase   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_fcs     <= n_fcs;
            r_ovf     <= n_ovf;
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Decode one step per cycle while the output can advance: held ff first, then the octet or the status
    always_comb begin
        limit     = (int'(r_max_decoded) > MAX_FRAME_BYTES) ?
                    t_cnt'(MAX_FRAME_BYTES) : r_max_decoded;
        room_now  = !r_ovf && (r_cnt < limit);
        room_next = ({1'b0, r_cnt} + 14'd1) < {1'b0, limit};
        adv       = !r_out_vld || i_out_ready;
        more      = 1'b0;
        n_cnt     = r_cnt;
        n_fcs     = r_fcs;
        n_ovf     = r_ovf;
        n_phase   = r_phase;
        n_out_vld = adv ? 1'b0 : r_out_vld;
        n_out     = r_out;
        o_pop     = 1'b0;
        if (i_cmd_vld && adv) begin
            if (i_cmd.hold_ff && !r_phase) begin
                more = (i_cmd.kind == CMD_CLOSE) ||
                       (i_cmd.byte_vld && room_now && room_next);
                if (room_now) begin
                    n_out_vld       = 1'b1;
                    n_out           = '0;
                    n_out.data      = ADDR_BYTE;
                    n_out.status    = STAT_OK;
                    n_out.last      = !more;
                    n_cnt           = r_cnt + 1'b1;
                    n_fcs           = fcs_update(r_fcs, ADDR_BYTE);
                end else begin
                    n_ovf = 1'b1;
                end
                // the following octet would not fit either
                if (i_cmd.byte_vld && !(room_now && room_next)) begin
                    n_ovf = 1'b1;
                end
                if (more) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                o_pop   = 1'b1;
                n_phase = 1'b0;
                unique case (i_cmd.kind)
                    CMD_DATA: begin
                        if (room_now) begin
                            n_out_vld    = 1'b1;
                            n_out        = '0;
                            n_out.data   = i_cmd.data;
                            n_out.status = STAT_OK;
                            n_out.last   = 1'b1;
                            n_cnt        = r_cnt + 1'b1;
                            n_fcs        = fcs_update(r_fcs, i_cmd.data);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    CMD_PREFIX: begin
                        n_fcs = FCS_PREFIX;
                    end
                    CMD_CLOSE: begin
                        n_out_vld       = 1'b1;
                        n_out           = '0;
                        n_out.is_status = 1'b1;
                        n_out.last      = 1'b1;
                        n_out.length    = (r_cnt >= t_cnt'(2)) ? r_cnt - t_cnt'(2) : '0;
                        if (i_cmd.runt) begin
                            n_out.status = STAT_RUNT;
                        end else if (r_ovf) begin
                            n_out.status = STAT_OVERFLOW;
                        end else if (r_fcs != FCS_GOOD) begin
                            n_out.status = STAT_BAD_FCS;
                        end else begin
                            n_out.status = STAT_OK;
                        end
                        n_cnt = '0;
                        n_fcs = FCS_INIT;
                        n_ovf = 1'b0;
                    end
                    default: begin
                        n_ovf = r_ovf;
                    end
                endcase
            end
        end
    end

endmodule

FILE: hw/rtl/async_hdlc_frame_decoder.sv
// Async HDLC deframer with FCS-16 check.
// Input stream s_axis: one raw received octet per beat in tdata[7:0].
// Output stream m_axis: tuser = 1 marks an end-of-frame status beat, 0 a
// decoded data octet (the two FCS octets included). tlast marks the final
// beat produced by one input octet. A leading ff 7d 23 prefix is checked
// but not passed on.
// Config channel i_cfg_*: limit of decoded octets per frame, always ready;
// write it only while the block is idle.
// Path: an input beat is registered in the command queue, then the back end
// registers its result in the output register.
// Throughput: one input beat per cycle while the command queue has room. An
// octet that yields two results (a broken prefix, or a flag closing a frame with
// the ff still held) holds the back end for both; the four-entry command queue absorbs this.
// Reset: waits for a first flag, limit back to 4096, no beat pending.
// A stall on m_axis holds the output beat; the queue fills and then
// s_axis_tready drops until the receiver takes beats again.
module async_hdlc_frame_decoder #(
    parameter int QUEUE_DEPTH = ahfd_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // [7:0] data_byte, [9:8] frame_status,
                                                      // [22:10] payload_length, [23] zero
    output logic                       m_axis_tuser,  // [0] is_status
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ahfd_pkg::CNT_W-1:0] i_cfg_data
);
    import ahfd_pkg::*;

    logic    push, full, pop, q_vld;
    t_cmd    push_cmd, q_cmd;
    t_result res;

    ahfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ahfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_cmd   (q_cmd)
    );

    ahfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_vld   (q_vld),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_vld   (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_res       (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {1'b0, res.length, res.status, res.data};
    assign m_axis_tuser = res.is_status;
    assign m_axis_tlast = res.last;

endmodule

FILE: sim/hdlc_fcs_checker.sv
`timescale 1ns / 100ps

module hdlc_fcs_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [7:0] rx_byte
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [23:0]                i_m_tdata,   // [7:0] data_byte, [9:8] frame_status,
                                                    // [22:10] payload_length, [23] zero
    input  logic                       i_m_tuser,   // [0] is_status
    input  logic                       i_m_tlast,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [ahfd_pkg::CNT_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);
    import ahfd_pkg::*;

    typedef enum logic [1:0] {
        PFX_START,
        PFX_GOT_FF,
        PFX_GOT_ESC,
        PFX_BODY
    } t_prefix;

    typedef struct packed {
        logic       is_status;
        logic [7:0] octet;
        t_status    status;
        t_cnt       length;
        logic       last;
    } t_beat;

    t_beat       expected_beats[$];
    t_beat       octet_beats[$];
    t_cnt        keep_limit;
    logic        in_frame;
    logic        esc_armed;
    t_prefix     prefix;
    logic [15:0] fcs_acc;
    int          kept_count;
    int          raw_count;
    logic        overran;

    // Fold one octet into the reflected FCS-16, LSB first
    function automatic logic [15:0] fcs_fold(input logic [15:0] crc, input logic [7:0] octet);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ octet[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ FCS_POLY;
            end
        end
        return acc;
    endfunction

    task automatic open_frame();
        esc_armed  = 1'b0;
        prefix     = PFX_START;
        fcs_acc    = FCS_INIT;
        kept_count = 0;
        raw_count  = 0;
        overran    = 1'b0;
    endtask

    // Unescape one octet and, if it survives, queue it as a data beat
    task automatic keep_octet(input logic [7:0] raw);
        logic [7:0] octet;
        t_beat      nb;
        int         cap;
        octet = raw;
        cap   = (keep_limit > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(keep_limit);
        if (overran || octet < CTRL_LIMIT) begin
            return;
        end
        if (octet == ESC_BYTE) begin
            esc_armed = 1'b1;
            return;
        end
        if (esc_armed) begin
            octet     = octet ^ ESC_XOR;
            esc_armed = 1'b0;
        end
        if (kept_count >= cap) begin
            overran = 1'b1;
            return;
        end
        nb       = '0;
        nb.octet = octet;
        octet_beats.push_back(nb);
        kept_count++;
        fcs_acc = fcs_fold(fcs_acc, octet);
    endtask

    // Work out every beat that one accepted raw octet causes
    task automatic predict_octet(input logic [7:0] raw);
        t_beat nb;
        octet_beats.delete();
        if (!in_frame) begin
            if (raw == FLAG_BYTE) begin
                in_frame = 1'b1;
                open_frame();
            end
        end else if (raw == FLAG_BYTE) begin
            // release a held address octet, then close with a status beat
            if (prefix == PFX_GOT_FF || prefix == PFX_GOT_ESC) begin
                keep_octet(ADDR_BYTE);
            end
            nb           = '0;
            nb.is_status = 1'b1;
            if (raw_count < RUNT_LIMIT) begin
                nb.status = STAT_RUNT;
            end else if (overran) begin
                nb.status = STAT_OVERFLOW;
            end else if (fcs_acc != FCS_GOOD) begin
                nb.status = STAT_BAD_FCS;
            end else begin
                nb.status = STAT_OK;
            end
            nb.length = (kept_count >= 2) ? t_cnt'(kept_count - 2) : '0;
            octet_beats.push_back(nb);
            open_frame();
        end else begin
            if (raw_count < RUNT_LIMIT) begin
                raw_count++;
            end
            case (prefix)
                PFX_START: begin
                    if (raw == ADDR_BYTE) begin
                        prefix = PFX_GOT_FF;
                    end else begin
                        prefix = PFX_BODY;
                        keep_octet(raw);
                    end
                end
                PFX_GOT_FF: begin
                    if (raw == ESC_BYTE) begin
                        prefix = PFX_GOT_ESC;
                    end else begin
                        prefix = PFX_BODY;
                        keep_octet(ADDR_BYTE);
                        keep_octet(raw);
                    end
                end
                PFX_GOT_ESC: begin
                    prefix = PFX_BODY;
                    if (raw == CTRL_ESC_ARG) begin
                        fcs_acc = FCS_PREFIX;
                    end else begin
                        keep_octet(ADDR_BYTE);
                        keep_octet(ESC_BYTE);
                        keep_octet(raw);
                    end
                end
                default: begin
                    keep_octet(raw);
                end
            endcase
        end
        // mark the final beat of this octet and hand all of them on
        if (octet_beats.size() > 0) begin
            nb      = octet_beats.pop_back();
            nb.last = 1'b1;
            octet_beats.push_back(nb);
        end
        while (octet_beats.size() > 0) begin
            expected_beats.push_back(octet_beats.pop_front());
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0d ns: %s expected %0h, got %0h", $time, what, want_v, got_v);
            o_errors++;
        end
    endtask

    // Compare output beats first, then predict from the input beat of this edge
    always @(posedge i_clk) begin : watch
        t_beat want;
        if (!i_rst_n) begin
            expected_beats.delete();
            keep_limit = t_cnt'(MAX_FRAME_BYTES);
            in_frame   = 1'b0;
            open_frame();
            o_errors   = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0d ns: no beat expected, got tuser %0b tdata %h tlast %0b",
                             $time, i_m_tuser, i_m_tdata, i_m_tlast);
                    o_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("is_status", want.is_status, i_m_tuser);
                    check_field("data_byte", want.octet, i_m_tdata[7:0]);
                    check_field("frame_status", want.status, i_m_tdata[9:8]);
                    check_field("payload_length", want.length, i_m_tdata[22:10]);
                    check_field("tdata pad", 16'h0, i_m_tdata[23]);
                    check_field("last", want.last, i_m_tlast);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                keep_limit = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_octet(i_s_tdata);
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ahfd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cnt        i_cfg_data;

    int          errors;
    int          pending;
    logic [7:0]  tx_octets[$];
    logic        tx_busy;
    logic        steady;
    int          octets_sent;

    async_hdlc_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    hdlc_fcs_checker watcher (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Idle cycles before a beat: often none, never in a steady stretch
    function automatic int pick_gap();
        if (steady || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(1, 16);
    endfunction

    // Octet mix that favors the framing codes
    function automatic logic [7:0] rand_octet();
        case ($urandom_range(0, 7))
            0:       return FLAG_BYTE;
            1:       return ESC_BYTE;
            2:       return ADDR_BYTE;
            3:       return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Frame check sequence for the sender side
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] octet);
        logic [15:0] acc;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            acc = (acc >> 1) ^ ((acc[0] ^ octet[i]) ? FCS_POLY : 16'h0);
        end
        return acc;
    endfunction

    // Send beats from the octet queue
    always begin : tx_side
        int gap;
        @(negedge i_clk);
        if (tx_octets.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            tx_busy = 1'b1;
            gap     = pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= tx_octets.pop_front();
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            tx_busy = 1'b0;
        end
    end

    // Stall the result stream at random before a beat
    always begin : rx_side
        int gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            m_axis_tready <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        m_axis_tready <= 1'b1;
        @(posedge i_clk);
        while (!m_axis_tvalid) @(posedge i_clk);
    end

    task automatic put_raw(input logic [7:0] octet);
        tx_octets.push_back(octet);
        octets_sent++;
    endtask

    // Escape an octet for the line, with stray control octets now and then
    task automatic put_coded(input logic [7:0] octet);
        if ($urandom_range(0, 15) == 0) begin
            put_raw(8'($urandom_range(0, 31)));
        end
        if (octet == FLAG_BYTE || octet == ESC_BYTE || octet < CTRL_LIMIT) begin
            put_raw(ESC_BYTE);
            if ($urandom_range(0, 15) == 0) begin
                put_raw(8'($urandom_range(0, 31)));
            end
            put_raw(octet ^ ESC_XOR);
        end else begin
            put_raw(octet);
        end
    endtask

    // Optional prefix, body, FCS and closing flag; optionally flip one bit after the FCS is set
    task automatic put_frame(input bit with_prefix, input int body_len, input bit spoil);
        logic [7:0]  body[$];
        logic [15:0] crc;
        int          k;
        crc = with_prefix ? FCS_PREFIX : FCS_INIT;
        for (int i = 0; i < body_len; i++) begin
            body.push_back(rand_octet());
            crc = crc_step(crc, body[i]);
        end
        crc = ~crc;
        body.push_back(crc[7:0]);
        body.push_back(crc[15:8]);
        if (spoil) begin
            k       = $urandom_range(0, body.size() - 1);
            body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (with_prefix) begin
            put_raw(ADDR_BYTE);
            put_raw(ESC_BYTE);
            put_raw(CTRL_ESC_ARG);
        end
        for (int i = 0; i < body.size(); i++) begin
            put_coded(body[i]);
        end
        put_raw(FLAG_BYTE);
    endtask

    // Mostly sound frames; the rest spoiled frames, runts, line noise, broken prefixes, bare flags
    task automatic put_random_frame();
        int n;
        int pick;
        while (tx_octets.size() != 0) @(negedge i_clk);
        steady = ($urandom_range(0, 7) == 0);
        n      = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
        pick   = $urandom_range(0, 19);
        if (pick < 12) begin
            put_frame(1'($urandom_range(0, 1)), n, 1'b0);
        end else if (pick < 15) begin
            put_frame(1'($urandom_range(0, 1)), n, 1'b1);
        end else if (pick < 17) begin
            repeat ($urandom_range(0, 4)) put_raw(rand_octet());
            put_raw(FLAG_BYTE);
        end else if (pick < 18) begin
            repeat ($urandom_range(1, 12)) put_raw(8'($urandom_range(0, 255)));
            put_raw(FLAG_BYTE);
        end else if (pick < 19) begin
            put_raw(ADDR_BYTE);
            if ($urandom_range(0, 1) == 1) begin
                put_raw(ESC_BYTE);
            end
            repeat ($urandom_range(1, 7)) put_raw(rand_octet());
            put_raw(FLAG_BYTE);
        end else begin
            repeat ($urandom_range(1, 3)) put_raw(FLAG_BYTE);
        end
    endtask

    // Hold until every queued octet is taken and every result is in
    task automatic drain();
        while (tx_octets.size() != 0 || tx_busy) @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the limit while idle; let octets with no result clear the pipe first
    task automatic write_limit(input t_cnt value);
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_cnt limit_plan[8];
        int   phase_end;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        tx_busy       = 1'b0;
        steady        = 1'b0;
        octets_sent   = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ignored before the first flag
        put_raw(8'h41);
        put_raw(ESC_BYTE);
        put_raw(ADDR_BYTE);
        // open, then back-to-back flags
        put_raw(FLAG_BYTE);
        put_raw(FLAG_BYTE);
        // flag while the address octet is held, after one and after two prefix octets
        put_raw(ADDR_BYTE);
        put_raw(FLAG_BYTE);
        put_raw(ADDR_BYTE);
        put_raw(ESC_BYTE);
        put_raw(FLAG_BYTE);
        // prefix broken on its second octet, then an escape dropped by the flag
        put_raw(ADDR_BYTE);
        put_raw(8'h41);
        put_raw(ESC_BYTE);
        put_raw(FLAG_BYTE);
        // prefix broken on its third octet, control octets dropped
        put_raw(ADDR_BYTE);
        put_raw(ESC_BYTE);
        put_raw(8'h24);
        put_raw(8'h00);
        put_raw(8'h1f);
        put_raw(8'h80);
        put_raw(FLAG_BYTE);
        // one sound frame with the prefix
        put_frame(1'b1, 2, 1'b0);

        // random part, one limit per phase, the extremes among them
        limit_plan    = '{13'd8191, 13'd1, 13'd0, 13'd6, 13'd4096, 13'd20, 13'd2, 13'd0};
        limit_plan[7] = t_cnt'($urandom_range(1, 8191));
        for (int phase = 0; phase < 8; phase++) begin
            write_limit(limit_plan[phase]);
            steady    = 1'b0;
            phase_end = octets_sent + 70;
            while (octets_sent < phase_end) begin
                put_random_frame();
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
